[hdl/usbsx_pkg.sv]
// shared types and constants for the usb-midi sysex packetizer
`timescale 1ns / 1ps

package usbsx_pkg;

   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_STOP  = 8'hF7;

   localparam logic [3:0] CIN_FULL = 4'h4;
   localparam logic [3:0] CIN_END1 = 4'h5;
   localparam logic [3:0] CIN_END2 = 4'h6;
   localparam logic [3:0] CIN_END3 = 4'h7;

   localparam logic [5:0] MAX_PAYLOAD_RESET  = 6'd40;
   localparam logic [3:0] CABLE_NUMBER_RESET = 4'd0;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CABLE_NUMBER = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] header;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic       message_end;
      logic       run_last;
   } rsp_type;

   // what one input byte asks of the back end
   typedef enum logic [1:0] {
      JOB_FULL,
      JOB_END2,
      JOB_END3,
      JOB_SPLIT
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   b0;
      logic [7:0]   b1;
      logic [7:0]   b2;
   } job_type;

endpackage

[hdl/usbsx_front.sv]
// front end: message framing state and packet classification
`timescale 1ns / 1ps

module usbsx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  usbsx_pkg::req_type req,
   input  logic [5:0]        max_payload,
   output logic              push,
   output usbsx_pkg::job_type job
);

   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic [1:0] pend_cnt_ff, pend_cnt_in;
   logic [5:0] pay_cnt_ff, pay_cnt_in;
   logic       in_msg_ff, in_msg_in;

   logic [7:0] s0, s1, s2;
   logic [1:0] nb;
   logic [5:0] pay_next;
   logic [5:0] limit;
   logic       closing;

   always_comb begin
      s0 = req.data_byte;
      s1 = 8'h00;
      s2 = 8'h00;
      nb = 2'd1;
      if (!in_msg_ff) begin
         s0 = usbsx_pkg::SYSEX_START;
         s1 = req.data_byte;
         nb = 2'd2;
      end else begin
         case (pend_cnt_ff)
            2'd1: begin
               s0 = pend0_ff;
               s1 = req.data_byte;
               nb = 2'd2;
            end
            2'd2: begin
               s0 = pend0_ff;
               s1 = pend1_ff;
               s2 = req.data_byte;
               nb = 2'd3;
            end
            default: begin
               s0 = req.data_byte;
               nb = 2'd1;
            end
         endcase
      end

      pay_next = in_msg_ff ? pay_cnt_ff + 6'd1 : 6'd1;
      limit    = (max_payload == 6'd0) ? 6'd1 : max_payload;
      closing  = req.flush || (pay_next == 6'd0) || (pay_next >= limit);

      push        = 1'b0;
      job.kind    = usbsx_pkg::JOB_FULL;
      job.b0      = s0;
      job.b1      = s1;
      job.b2      = s2;
      pend0_in    = pend0_ff;
      pend1_in    = pend1_ff;
      pend_cnt_in = pend_cnt_ff;
      pay_cnt_in  = pay_cnt_ff;
      in_msg_in   = in_msg_ff;

      if (accept) begin
         if (closing) begin
            push        = 1'b1;
            in_msg_in   = 1'b0;
            pend_cnt_in = 2'd0;
            pay_cnt_in  = 6'd0;
            case (nb)
               2'd3: job.kind = usbsx_pkg::JOB_SPLIT;
               2'd2: begin
                  job.kind = usbsx_pkg::JOB_END3;
                  job.b2   = usbsx_pkg::SYSEX_STOP;
               end
               default: begin
                  job.kind = usbsx_pkg::JOB_END2;
                  job.b1   = usbsx_pkg::SYSEX_STOP;
                  job.b2   = 8'h00;
               end
            endcase
         end else begin
            in_msg_in  = 1'b1;
            pay_cnt_in = pay_next;
            if (nb == 2'd3) begin
               push        = 1'b1;
               pend_cnt_in = 2'd0;
            end else begin
               pend0_in    = s0;
               pend1_in    = s1;
               pend_cnt_in = nb;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= 2'd0;
         pay_cnt_ff  <= 6'd0;
         in_msg_ff   <= 1'b0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
         pay_cnt_ff  <= pay_cnt_in;
         in_msg_ff   <= in_msg_in;
      end
   end

   always_ff @(posedge clock) begin
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

endmodule

[hdl/usbsx_fifo.sv]
// short job queue between front and back end
`timescale 1ns / 1ps

module usbsx_fifo #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  usbsx_pkg::job_type push_job,
   input  logic               pop,
   output usbsx_pkg::job_type head,
   output logic               empty,
   output logic               full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   usbsx_pkg::job_type slot_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == CNT_W'(0));
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hdl/usbsx_back.sv]
// back end: turns queued jobs into packets in the output register
`timescale 1ns / 1ps

module usbsx_back (
   input  logic               clock,
   input  logic               reset,
   input  usbsx_pkg::job_type head,
   input  logic               empty,
   input  logic [3:0]         cable_number,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output usbsx_pkg::rsp_type rsp_data
);

   logic               valid_ff, valid_in;
   logic               phase_ff, phase_in;
   usbsx_pkg::rsp_type pkt_ff, pkt_in;
   logic               load, take;
   logic [3:0]         code;

   assign load      = !valid_ff || !rsp_stall;
   assign take      = load && !empty;
   assign rsp_valid = valid_ff;
   assign rsp_data  = pkt_ff;

   always_comb begin
      code               = usbsx_pkg::CIN_FULL;
      pkt_in.first_byte  = head.b0;
      pkt_in.second_byte = head.b1;
      pkt_in.third_byte  = head.b2;
      pkt_in.message_end = 1'b1;
      pkt_in.run_last    = 1'b1;
      pop                = take;
      phase_in           = phase_ff;
      case (head.kind)
         usbsx_pkg::JOB_FULL: begin
            pkt_in.message_end = 1'b0;
         end
         usbsx_pkg::JOB_END2: code = usbsx_pkg::CIN_END2;
         usbsx_pkg::JOB_END3: code = usbsx_pkg::CIN_END3;
         usbsx_pkg::JOB_SPLIT: begin
            if (!phase_ff) begin
               // full packet first, stop byte follows next beat
               pkt_in.message_end = 1'b0;
               pkt_in.run_last    = 1'b0;
               pop                = 1'b0;
               if (take) begin
                  phase_in = 1'b1;
               end
            end else begin
               code               = usbsx_pkg::CIN_END1;
               pkt_in.first_byte  = usbsx_pkg::SYSEX_STOP;
               pkt_in.second_byte = 8'h00;
               pkt_in.third_byte  = 8'h00;
               if (take) begin
                  phase_in = 1'b0;
               end
            end
         end
         default: code = usbsx_pkg::CIN_FULL;
      endcase
      pkt_in.header = {cable_number, code};
      valid_in = take ? 1'b1 : (load ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pkt_ff <= pkt_in;
      end
   end

endmodule

[hdl/usb_midi_sysex_packetizer_unit.sv]
// top level of the usb-midi sysex packetizer
`timescale 1ns / 1ps

// channel | ports                              | beat
// --------+------------------------------------+---------------------------------
// req     | req_valid, req_stall, req_data     | one data byte plus flush flag
// rsp     | rsp_valid, rsp_stall, rsp_data     | one 4-byte usb-midi event packet
// csr     | csr_write_en, csr_index, csr_wdata | one register write, no handshake
//
// one req beat a cycle while req_stall is low; results pass the job queue, then the output register
// a closing beat with four bytes to send needs two packets, so two rsp beats
// the back end serialises those two packets; the job stays queued until the second is loaded
// reset is synchronous: no message open, queue empty, registers back to defaults
// req_stall rises only while the job queue is full; rsp_stall just holds the output

module usb_midi_sysex_packetizer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  usbsx_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output usbsx_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_write_en,
   input  logic [usbsx_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [usbsx_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   logic [5:0] max_payload_ff, max_payload_in;
   logic [3:0] cable_ff, cable_in;

   // front to queue
   logic               req_accept;
   logic               push;
   usbsx_pkg::job_type push_job;

   // queue to back
   usbsx_pkg::job_type head;
   logic               empty, full, pop;

   always_comb begin
      max_payload_in = max_payload_ff;
      cable_in       = cable_ff;
      if (csr_write_en) begin
         case (csr_index)
            usbsx_pkg::CSR_MAX_PAYLOAD:  max_payload_in = csr_wdata;
            usbsx_pkg::CSR_CABLE_NUMBER: cable_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= usbsx_pkg::MAX_PAYLOAD_RESET;
         cable_ff       <= usbsx_pkg::CABLE_NUMBER_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
         cable_ff       <= cable_in;
      end
   end

   // accept whenever the queue has room for a job
   assign req_stall  = full;
   assign req_accept = req_valid && !full;

   usbsx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req         (req_data),
      .max_payload (max_payload_ff),
      .push        (push),
      .job         (push_job)
   );

   usbsx_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   usbsx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .empty        (empty),
      .cable_number (cable_ff),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

[sim/usb_midi_sysex_packetizer_unit_test.sv]
// self-checking testbench for the usb-midi sysex packetizer
`timescale 1ns / 1ps

import usbsx_pkg::*;

// packet predictor and in-order checker for the sysex packetizer
class sysex_scoreboard;
   rsp_type    packets_due[$];
   logic [5:0] max_payload;
   logic [3:0] cable_number;
   logic [7:0] held_bytes[2];
   int         held_count;
   logic [5:0] payload_count;
   bit         msg_open;
   int         errors;
   int         packets_seen;
   int         messages_closed;
   int         split_closes;

   function new();
      max_payload     = MAX_PAYLOAD_RESET;
      cable_number    = CABLE_NUMBER_RESET;
      held_count      = 0;
      payload_count   = '0;
      msg_open        = 1'b0;
      errors          = 0;
      packets_seen    = 0;
      messages_closed = 0;
      split_closes    = 0;
   endfunction

   function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      if (index == CSR_MAX_PAYLOAD)
         max_payload = value;
      else if (index == CSR_CABLE_NUMBER)
         cable_number = value[3:0];
   endfunction

   function void post_packet(logic [3:0] code, logic [7:0] b0, logic [7:0] b1,
                             logic [7:0] b2, logic closes, logic last);
      rsp_type p;
      p.header      = {cable_number, code};
      p.first_byte  = b0;
      p.second_byte = b1;
      p.third_byte  = b2;
      p.message_end = closes;
      p.run_last    = last;
      packets_due.push_back(p);
   endfunction

   // work out the packets that one accepted byte gives rise to
   function void note_beat(req_type beat);
      logic [7:0] seq[4];
      int         n;
      int         limit;
      bit         closing;
      n     = 0;
      limit = (max_payload == 0) ? 1 : int'(max_payload);
      if (!msg_open) begin
         msg_open      = 1'b1;
         held_count    = 0;
         payload_count = '0;
         seq[n]        = SYSEX_START;
         n++;
      end
      for (int i = 0; i < held_count; i++) begin
         seq[n] = held_bytes[i];
         n++;
      end
      seq[n] = beat.data_byte;
      n++;
      payload_count = payload_count + 6'd1;
      closing = beat.flush || payload_count == 0 || int'(payload_count) >= limit;

      if (closing) begin
         seq[n] = SYSEX_STOP;
         n++;
         if (n == 4) begin
            // four bytes to close: full packet, then the stop byte alone
            post_packet(CIN_FULL, seq[0], seq[1], seq[2], 1'b0, 1'b0);
            post_packet(CIN_END1, seq[3], 8'h00, 8'h00, 1'b1, 1'b1);
            split_closes++;
         end else if (n == 3) begin
            post_packet(CIN_END3, seq[0], seq[1], seq[2], 1'b1, 1'b1);
         end else begin
            post_packet(CIN_END2, seq[0], seq[1], 8'h00, 1'b1, 1'b1);
         end
         messages_closed++;
         msg_open      = 1'b0;
         held_count    = 0;
         payload_count = '0;
      end else if (n == 3) begin
         post_packet(CIN_FULL, seq[0], seq[1], seq[2], 1'b0, 1'b1);
         held_count = 0;
      end else begin
         for (int i = 0; i < n; i++)
            held_bytes[i] = seq[i];
         held_count = n;
      end
   endfunction

   function void check_packet(rsp_type got);
      rsp_type    want;
      logic [7:0] want_f[6];
      logic [7:0] got_f[6];
      string      names[6];
      packets_seen++;
      if (packets_due.size() == 0) begin
         $display("%0t ns: packet with none expected, got %h", $time, got);
         errors++;
         return;
      end
      want   = packets_due.pop_front();
      names  = '{"header", "first_byte", "second_byte", "third_byte",
                 "message_end", "run_last"};
      want_f = '{want.header, want.first_byte, want.second_byte, want.third_byte,
                 {7'd0, want.message_end}, {7'd0, want.run_last}};
      got_f  = '{got.header, got.first_byte, got.second_byte, got.third_byte,
                 {7'd0, got.message_end}, {7'd0, got.run_last}};
      for (int i = 0; i < 6; i++)
         if (want_f[i] !== got_f[i]) begin
            $display("%0t ns: %s expected %02h got %02h", $time, names[i],
                     want_f[i], got_f[i]);
            errors++;
         end
   endfunction

   function void check_left_over();
      if (packets_due.size() != 0) begin
         $display("%0t ns: %0d packets expected but never seen, oldest %h", $time,
                  packets_due.size(), packets_due[0]);
         errors++;
      end
   endfunction
endclass

module usb_midi_sysex_packetizer_unit_test;

   localparam int STALL_LIMIT  = 2000;   // cycles with no beat or register write before giving up
   localparam int TARGET_BYTES = 950;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   sysex_scoreboard board;
   bit              quiet_phase = 1'b0;   // no gaps on either side while set
   int              bytes_sent = 0;
   int              csr_writes = 0;
   int              rsp_hold = 0;
   int              idle_cycles = 0;

   usb_midi_sysex_packetizer_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // result side: check every accepted packet, then hold stall for a random spell
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_packet(rsp_data);
         rsp_hold = quiet_phase ? 0 : $urandom_range(0, 18);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold > 0);
   end

   // watchdog: any beat on either channel or a register write counts as progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // one data byte on the req channel, after a random gap; returns at its accepting edge
   task automatic send_byte(input logic [7:0] value, input logic flush_bit);
      req_type beat;
      int      gap;
      beat.data_byte = value;
      beat.flush     = flush_bit;
      gap = quiet_phase ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      board.note_beat(beat);
      bytes_sent++;
   endtask

   // sender holds off until every predicted packet has been taken
   task automatic wait_for_packets_out();
      req_valid <= 1'b0;
      while (board.packets_due.size() != 0) @(posedge clock);
   endtask

   // registers change only with the block drained; a held byte makes no packet,
   // so the pipeline is also given time to settle first
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      wait_for_packets_out();
      repeat (5) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.set_reg(index, value);
      csr_writes++;
   endtask

   initial begin
      int          phase;
      int          beats_in_phase;
      int          limit;
      int          msg_left;
      bit          noisy;
      logic [5:0]  new_max;
      logic [3:0]  new_cable;
      logic        flush_bit;

      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset values: every closing code and the split close
      send_byte(8'h00, 1'b1);                          // open and close in one byte
      send_byte(8'hFF, 1'b1);
      send_byte(8'h12, 1'b0);                          // two bytes held, close splits
      send_byte(8'h34, 1'b1);
      send_byte(8'h56, 1'b0);                          // full packet then two-byte close
      send_byte(8'h78, 1'b0);
      send_byte(8'h9A, 1'b1);
      send_byte(8'hA5, 1'b0);                          // one byte held, three-byte close
      send_byte(8'h5A, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b1);

      // zero limit behaves as one: each byte closes its own message
      write_csr(CSR_CABLE_NUMBER, 6'd15);
      write_csr(CSR_MAX_PAYLOAD, 6'd0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);

      // limit lowered below the count of an open message
      write_csr(CSR_MAX_PAYLOAD, 6'd40);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'hF7, 1'b0);
      write_csr(CSR_MAX_PAYLOAD, 6'd2);
      send_byte(8'h7F, 1'b0);

      // random phases: each picks a setting, then streams mostly well-formed messages;
      // messages left open across a phase change meet the new limit mid-way
      phase = 0;
      while (bytes_sent < TARGET_BYTES) begin
         case (phase)
            0:       begin new_max = 6'd63; new_cable = 4'd15; end
            1:       begin new_max = 6'd1;  new_cable = 4'd0;  end
            2:       begin new_max = 6'd0;  new_cable = 4'd9;  end
            default: begin
               case ($urandom_range(0, 4))
                  0:       new_max = 6'd63;
                  1:       new_max = 6'd1;
                  2:       new_max = 6'd0;
                  3:       new_max = 6'($urandom_range(2, 6));
                  default: new_max = 6'($urandom_range(1, 63));
               endcase
               new_cable = 4'($urandom_range(0, 15));
            end
         endcase
         write_csr(CSR_MAX_PAYLOAD, new_max);
         write_csr(CSR_CABLE_NUMBER, {2'b00, new_cable});

         limit          = (new_max == 0) ? 1 : int'(new_max);
         quiet_phase    = ($urandom_range(0, 3) == 0);
         noisy          = ($urandom_range(0, 4) == 0);
         beats_in_phase = $urandom_range(20, 80);
         msg_left       = $urandom_range(1, 4);

         for (int k = 0; k < beats_in_phase; k++) begin
            // sender waits for the result side to empty now and then
            if (k == beats_in_phase / 2 && phase % 4 == 1)
               wait_for_packets_out();
            if (noisy)
               flush_bit = ($urandom_range(0, 7) == 0);
            else
               flush_bit = (msg_left == 1);
            send_byte(8'($urandom_range(0, 255)), flush_bit);
            msg_left--;
            if (flush_bit || msg_left <= 0)
               msg_left = $urandom_range(0, 1) ? $urandom_range(1, 4)
                                               : $urandom_range(1, limit + 2);
         end
         quiet_phase = 1'b0;
         phase++;
      end

      wait_for_packets_out();
      repeat (10) @(posedge clock);
      board.check_left_over();

      $display("covered %0d data bytes in %0d settings, %0d register writes",
               bytes_sent, phase + 3, csr_writes);
      $display("checked %0d packets, %0d messages closed, %0d of them by a split close",
               board.packets_seen, board.messages_closed, board.split_closes);
      if (board.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
